>>> hdl/dsph_pkg.sv
// ----------------------------------------------------------------------------
// dsph_pkg: shared types, tables and functions
// DES permutation tables, S-boxes and the transaction record that moves
// along the round cell chain.
// ----------------------------------------------------------------------------
package dsph_pkg;

  localparam int HashRounds = 25;
  localparam int KeyBytes   = 8;
  localparam int NumCells   = HashRounds * 16;

  typedef struct packed {
    logic        valid;
    logic        mode;
    logic [7:0]  salt_first;
    logic [7:0]  salt_second;
    logic [63:0] stored_hash;
    logic [31:0] left;
    logic [31:0] right;
    logic [27:0] key_c;
    logic [27:0] key_d;
  } pkt_t;

  localparam byte unsigned T_IP [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam byte unsigned T_FP [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam byte unsigned T_E [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam byte unsigned T_P [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam byte unsigned T_PC1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
    19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam byte unsigned T_PC2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic T_SHIFT_TWO [16] = '{0,0,1,1,1,1,1,1,0,1,1,1,1,1,1,0};
  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_fp(logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(T_FP[i])];
    return y;
  endfunction

  function automatic logic [55:0] perm_pc1(logic [63:0] x);
    logic [55:0] y;
    for (int i = 0; i < 56; i++) y[55-i] = x[64-int'(T_PC1[i])];
    return y;
  endfunction

  function automatic logic [47:0] perm_pc2(logic [55:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[47-i] = x[56-int'(T_PC2[i])];
    return y;
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] r, logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] y;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(T_E[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) y[31-i] = s[32-int'(T_P[i])];
    return y;
  endfunction

endpackage

>>> hdl/dsph_keyprep.sv
// ----------------------------------------------------------------------------
// dsph_keyprep: key string assembly stage
// Builds the eight key bytes from password and decimal salt digits, applies
// PC-1 and registers the record that enters the round cell chain.
// ----------------------------------------------------------------------------
module dsph_keyprep (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic                mode,
  input  logic [63:0]         password_bytes,
  input  logic [3:0]          password_length,
  input  logic [7:0]          salt_first,
  input  logic [7:0]          salt_second,
  input  logic [63:0]         stored_hash,
  output dsph_pkg::pkt_t      q
);
  import dsph_pkg::*;

  // Splits a byte into decimal digits, most significant first.
  function automatic logic [11:0] to_digits(logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [3:0]  t;
    logic [17:0] m;
    logic [3:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(v - 8'(h) * 8'd100);
    m = 18'(r) * 18'd205;
    t = 4'(m >> 11);
    o = 4'(r - 7'(t) * 7'd10);
    return {2'b00, h, t, o};
  endfunction

  logic [11:0] dg1, dg2;
  logic [1:0]  n1, n2;
  logic [3:0]  len;
  logic [63:0] key;
  pkt_t        q_next;

  always_comb begin
    int j;
    dg1 = to_digits(salt_first);
    dg2 = to_digits(salt_second);
    n1  = (salt_first >= 8'd100) ? 2'd3 : ((salt_first >= 8'd10) ? 2'd2 : 2'd1);
    n2  = (salt_second >= 8'd100) ? 2'd3 : ((salt_second >= 8'd10) ? 2'd2 : 2'd1);
    len = (password_length > 4'd8) ? 4'd8 : password_length;
    key = '0;
    for (int k = 0; k < KeyBytes; k++) begin
      j = k - int'(len);
      if (k < int'(len)) begin
        key[63-8*k -: 8] = password_bytes[63-8*k -: 8];
      end else if (j < int'(n1)) begin
        key[63-8*k -: 8] = {4'h3, dg1[4*(int'(n1)-1-j) +: 4]};
      end else if (j - int'(n1) < int'(n2)) begin
        key[63-8*k -: 8] = {4'h3, dg2[4*(int'(n2)-1-(j-int'(n1))) +: 4]};
      end
    end
    q_next.valid       = in_valid;
    q_next.mode        = mode;
    q_next.salt_first  = salt_first;
    q_next.salt_second = salt_second;
    q_next.stored_hash = stored_hash;
    q_next.left        = '0;
    q_next.right       = '0;
    {q_next.key_c, q_next.key_d} = perm_pc1(key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

>>> hdl/dsph_cell.sv
// ----------------------------------------------------------------------------
// dsph_cell: one DES round
// Rotates the key halves, forms the subkey and applies one Feistel round.
// The sixteenth round of each encryption keeps its halves unswapped.
// ----------------------------------------------------------------------------
module dsph_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           shift_two,
  input  logic           last_round,
  input  dsph_pkg::pkt_t d,
  output dsph_pkg::pkt_t q
);
  import dsph_pkg::*;

  logic [27:0] c_rot, d_rot;
  logic [31:0] f_out;
  pkt_t        q_next;

  always_comb begin
    c_rot  = shift_two ? {d.key_c[25:0], d.key_c[27:26]} : {d.key_c[26:0], d.key_c[27]};
    d_rot  = shift_two ? {d.key_d[25:0], d.key_d[27:26]} : {d.key_d[26:0], d.key_d[27]};
    f_out  = feistel(d.right, perm_pc2({c_rot, d_rot}));
    q_next = d;
    q_next.key_c = c_rot;
    q_next.key_d = d_rot;
    if (last_round) begin
      q_next.left  = d.left ^ f_out;
      q_next.right = d.right;
    end else begin
      q_next.left  = d.right;
      q_next.right = d.left ^ f_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= q_next;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst) !en |=> q.valid == $past(q.valid))
    else $error("cell dropped or created a transaction while stalled");
  a_move: assert property (@(posedge clk) disable iff (rst) en |=> q.valid == $past(d.valid))
    else $error("cell did not take its neighbor's transaction");
  a_last: assert property (@(posedge clk) last_round |-> !shift_two)
    else $error("last round of an encryption must use a single-bit rotation");

endmodule

>>> hdl/des_salted_password_hash_core.sv
// ----------------------------------------------------------------------------
// des_salted_password_hash_core: salted DES password hash, 25 iterations
// Fully unrolled chain of 400 DES round cells behind a key assembly stage.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while the output side keeps up. Each
// passes from input acceptance to its result through one key assembly
// stage, 400 round cells (25 encryptions of 16 rounds) and an output register
// holding the final permutation and the compare. The whole chain advances
// together; it stalls only while a result waits in the output register.
module des_salted_password_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [63:0] password_bytes,
  input  logic [3:0]  password_length,
  input  logic [7:0]  salt_first,
  input  logic [7:0]  salt_second,
  input  logic [63:0] stored_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  salt_first_out,
  output logic [7:0]  salt_second_out,
  output logic [63:0] hash_value,
  output logic        matched
);
  import dsph_pkg::*;

  logic        en;
  pkt_t        chain [NumCells+1];
  logic [63:0] hash_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  dsph_keyprep u_keyprep (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .mode(mode),
    .password_bytes(password_bytes), .password_length(password_length),
    .salt_first(salt_first), .salt_second(salt_second),
    .stored_hash(stored_hash), .q(chain[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    dsph_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .shift_two(T_SHIFT_TWO[g % 16]),
      .last_round((g % 16) == 15),
      .d(chain[g]), .q(chain[g+1])
    );
  end

  assign hash_next = perm_fp({chain[NumCells].left, chain[NumCells].right});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain[NumCells].valid;
    end
    if (en) begin
      salt_first_out  <= chain[NumCells].salt_first;
      salt_second_out <= chain[NumCells].salt_second;
      hash_value      <= hash_next;
      matched         <= chain[NumCells].mode && (hash_next == chain[NumCells].stored_hash);
    end
  end

endmodule
